// ===== design/pol_pkg.sv =====
// Package for the positional ordered list: request and response types,
// command and status codes, and the control word broadcast to the cells.
// No dependencies.
package pol_pkg;

   localparam int CNT_W = 7;

   localparam logic [2:0] CMD_INS_FRONT = 3'd0;
   localparam logic [2:0] CMD_INS_BACK  = 3'd1;
   localparam logic [2:0] CMD_INS_POS   = 3'd2;
   localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
   localparam logic [2:0] CMD_DEL_BACK  = 3'd4;
   localparam logic [2:0] CMD_DEL_POS   = 3'd5;
   localparam logic [2:0] CMD_DUMP      = 3'd6;

   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_INVALID = 3'd1;
   localparam logic [2:0] STAT_BOUNDS  = 3'd2;
   localparam logic [2:0] STAT_EMPTY   = 3'd3;
   localparam logic [2:0] STAT_FULL    = 3'd4;

   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_DELETE = 2'd2;
   localparam logic [1:0] CELL_ROTATE = 2'd3;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] value;
      logic [7:0]         position;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] entry;
      logic [6:0]         length;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [CNT_W-1:0] idx;
      logic [CNT_W-1:0] count;
   } cell_ctrl_type;

endpackage

// ===== design/pol_cell.sv =====
// One cell of the list chain: holds a single entry and takes its next value
// from its left or right neighbour, the insert value or the head of the chain.
// Depends on pol_pkg.
module pol_cell
   import pol_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic signed [31:0]  value,
   input  logic signed [31:0]  left_data,
   input  logic signed [31:0]  right_data,
   input  logic signed [31:0]  head_data,
   output logic signed [31:0]  data
);

   localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
   localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (MY_IDX > ctrl.idx) data_in = left_data;
            else if (MY_IDX == ctrl.idx) data_in = value;
         end
         CELL_DELETE: begin
            if (MY_IDX >= ctrl.idx) data_in = right_data;
         end
         CELL_ROTATE: begin
            // The cell at the tail of the occupied run receives the old head.
            if (MY_NEXT == ctrl.count) data_in = head_data;
            else if (MY_NEXT < ctrl.count) data_in = right_data;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== design/positional_ordered_list.sv =====
// Top level of the positional ordered list: command decode, fill count,
// dump sequencer and response register around a chain of pol_cell instances.
// Depends on pol_pkg and pol_cell.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+----------------------------
//   req      | in        | req_valid, req_stall | req_data  (req_type)
//   rsp      | out       | rsp_valid, rsp_stall | rsp_data  (rsp_type)
//
// An insert or a delete moves every cell at once, so the whole list shifts by
// one position when the request is accepted. A dump of n entries first enters
// the dump state, then gives one response per cycle while the response is not
// stalled; the chain rotates by one cell per response, which leaves the list in
// its original order. Reset (synchronous, active high) empties the list and
// the response register; the entry storage itself is not cleared.
// A stalled response holds the response register, and no request is taken
// until that register can be loaded.
module positional_ordered_list
   import pol_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   // Control state.
   logic             state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] dump_left_ff, dump_left_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             out_free;
   logic             req_fire;
   cell_ctrl_type    ctrl;

   logic signed [31:0] cell_data [DEPTH];

   // The response register may be loaded when it is empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff == ST_DUMP) || !out_free;
   assign req_fire  = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Command decode, status checks and the control word for the cells.
   always_comb begin
      logic [8:0] pos_ext;
      logic [8:0] cnt_ext;
      logic [2:0] status;
      pos_ext = {1'b0, req_data.position};
      cnt_ext = 9'(count_ff);
      status  = STAT_OK;

      state_in     = state_ff;
      count_in     = count_ff;
      dump_left_in = dump_left_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ctrl.op      = CELL_HOLD;
      ctrl.idx     = '0;
      ctrl.count   = count_ff;

      if (req_fire) begin
         case (req_data.command)
            CMD_INS_FRONT: begin
               if (count_ff >= DEPTH_C) status = STAT_FULL;
               else begin
                  ctrl.op  = CELL_INSERT;
                  ctrl.idx = '0;
               end
            end
            CMD_INS_BACK: begin
               if (count_ff >= DEPTH_C) status = STAT_FULL;
               else begin
                  ctrl.op  = CELL_INSERT;
                  ctrl.idx = count_ff;
               end
            end
            CMD_INS_POS: begin
               if (req_data.position == 8'd0) status = STAT_INVALID;
               else if (count_ff >= DEPTH_C) status = STAT_FULL;
               else if (pos_ext > cnt_ext + 9'd1) status = STAT_BOUNDS;
               else begin
                  ctrl.op  = CELL_INSERT;
                  ctrl.idx = CNT_W'(pos_ext - 9'd1);
               end
            end
            CMD_DEL_FRONT: begin
               if (count_ff == '0) status = STAT_EMPTY;
               else begin
                  ctrl.op  = CELL_DELETE;
                  ctrl.idx = '0;
               end
            end
            CMD_DEL_BACK: begin
               if (count_ff == '0) status = STAT_EMPTY;
               else begin
                  ctrl.op  = CELL_DELETE;
                  ctrl.idx = count_ff - CNT_W'(1);
               end
            end
            CMD_DEL_POS: begin
               if (req_data.position == 8'd0) status = STAT_INVALID;
               else if (count_ff == '0) status = STAT_EMPTY;
               else if (pos_ext > cnt_ext) status = STAT_BOUNDS;
               else begin
                  ctrl.op  = CELL_DELETE;
                  ctrl.idx = CNT_W'(pos_ext - 9'd1);
               end
            end
            CMD_DUMP: begin
               if (count_ff == '0) status = STAT_EMPTY;
            end
            default: status = STAT_INVALID;
         endcase

         if (ctrl.op == CELL_INSERT) count_in = count_ff + CNT_W'(1);
         else if (ctrl.op == CELL_DELETE) count_in = count_ff - CNT_W'(1);

         if (req_data.command == CMD_DUMP && count_ff != '0) begin
            // Responses follow from the dump sequencer.
            state_in     = ST_DUMP;
            dump_left_in = count_ff;
         end else begin
            rsp_valid_in  = 1'b1;
            rsp_in.status = status;
            rsp_in.entry  = '0;
            rsp_in.length = 7'(count_in);
            rsp_in.last   = 1'b1;
         end
      end else if (state_ff == ST_DUMP && out_free) begin
         // Emit the head and rotate the occupied run by one cell.
         ctrl.op       = CELL_ROTATE;
         rsp_valid_in  = 1'b1;
         rsp_in.status = STAT_OK;
         rsp_in.entry  = cell_data[0];
         rsp_in.length = 7'(count_ff);
         rsp_in.last   = (dump_left_ff == CNT_W'(1));
         dump_left_in  = dump_left_ff - CNT_W'(1);
         if (dump_left_ff == CNT_W'(1)) state_in = ST_IDLE;
      end
   end

   // The cell chain.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] left_d;
      logic signed [31:0] right_d;
      if (i == 0) begin : g_head
         assign left_d = req_data.value;
      end else begin : g_body
         assign left_d = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_d = cell_data[i];
      end else begin : g_mid
         assign right_d = cell_data[i+1];
      end
      pol_cell #(.IDX(i)) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .value      (req_data.value),
         .left_data  (left_d),
         .right_data (right_d),
         .head_data  (cell_data[0]),
         .data       (cell_data[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dump_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_left_ff <= dump_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // The fill count never exceeds the chain length.
   assert property (@(posedge clock) disable iff (reset) count_ff <= DEPTH_C)
      else $error("fill count beyond depth");

   // During a dump there is always at least one entry left to send.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP) |-> (dump_left_ff != '0 && dump_left_ff <= count_ff))
      else $error("dump counter out of range");

   // The list length only changes in a cycle in which a request is taken.
   assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> count_ff == $past(count_ff))
      else $error("fill count changed without a request");

   // The final dump response returns the sequencer to idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP && out_free && dump_left_ff == CNT_W'(1))
         |=> (state_ff == ST_IDLE && rsp_valid_ff && rsp_ff.last))
      else $error("dump did not finish with a last response");

endmodule

// ===== test/positional_ordered_list_check.sv =====
`timescale 1ns / 100ps
// Checker for the positional ordered list. It watches both channels, keeps its own copy of
// the list and matches every response against the oldest one still awaited.
// Depends on pol_pkg.
module positional_ordered_list_check
   import pol_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      pending,
   output int      responses_seen
);

   logic signed [31:0] list_store [DEPTH];
   int                 list_len;
   rsp_type            awaited_rsp [$];
   int                 fault_count;
   int                 seen_count;

   task automatic await_response(logic [2:0] st, logic signed [31:0] word, logic lst);
      rsp_type r;
      r.status = st;
      r.entry  = word;
      r.length = list_len[6:0];
      r.last   = lst;
      awaited_rsp.push_back(r);
   endtask

   task automatic insert_entry(int idx, logic signed [31:0] word);
      for (int i = list_len; i > idx; i--) list_store[i] = list_store[i - 1];
      list_store[idx] = word;
      list_len++;
   endtask

   task automatic remove_entry(int idx);
      for (int i = idx; i + 1 < list_len; i++) list_store[i] = list_store[i + 1];
      list_len--;
   endtask

   // Applies one accepted request to the local list and queues its responses.
   task automatic apply_request(req_type r);
      logic [2:0] st;
      int         pos;
      st  = STAT_OK;
      pos = int'(r.position);
      case (r.command)
         CMD_INS_FRONT: begin
            if (list_len >= DEPTH) st = STAT_FULL;
            else insert_entry(0, r.value);
         end
         CMD_INS_BACK: begin
            if (list_len >= DEPTH) st = STAT_FULL;
            else insert_entry(list_len, r.value);
         end
         CMD_INS_POS: begin
            if (pos == 0) st = STAT_INVALID;
            else if (list_len >= DEPTH) st = STAT_FULL;
            else if (pos > list_len + 1) st = STAT_BOUNDS;
            else insert_entry(pos - 1, r.value);
         end
         CMD_DEL_FRONT: begin
            if (list_len == 0) st = STAT_EMPTY;
            else remove_entry(0);
         end
         CMD_DEL_BACK: begin
            if (list_len == 0) st = STAT_EMPTY;
            else remove_entry(list_len - 1);
         end
         CMD_DEL_POS: begin
            if (pos == 0) st = STAT_INVALID;
            else if (list_len == 0) st = STAT_EMPTY;
            else if (pos > list_len) st = STAT_BOUNDS;
            else remove_entry(pos - 1);
         end
         CMD_DUMP: begin
            if (list_len == 0) begin
               await_response(STAT_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < list_len; i++)
                  await_response(STAT_OK, list_store[i], i == list_len - 1);
            end
            return;
         end
         default: st = STAT_INVALID;
      endcase
      await_response(st, '0, 1'b1);
   endtask

   task automatic check_response(rsp_type got);
      rsp_type want;
      seen_count++;
      if (awaited_rsp.size() == 0) begin
         $error("unexpected response: status %0d entry %0d length %0d last %0d",
                got.status, got.entry, got.length, got.last);
         fault_count++;
         return;
      end
      want = awaited_rsp.pop_front();
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         fault_count++;
      end
      if (got.entry !== want.entry) begin
         $error("entry: expected %0d, got %0d", want.entry, got.entry);
         fault_count++;
      end
      if (got.length !== want.length) begin
         $error("length: expected %0d, got %0d", want.length, got.length);
         fault_count++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, got.last);
         fault_count++;
      end
   endtask

   initial begin
      list_len    = 0;
      fault_count = 0;
      seen_count  = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         list_len = 0;
         awaited_rsp.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_response(rsp_data);
         if (req_valid && !req_stall) apply_request(req_data);
      end
      pending        <= awaited_rsp.size();
      mismatches     <= fault_count;
      responses_seen <= seen_count;
   end

endmodule

// ===== test/positional_ordered_list_test.sv =====
`timescale 1ns / 100ps
// Top of the positional ordered list testbench: clock, reset, request stimulus and the
// verdict. Depends on pol_pkg, positional_ordered_list and positional_ordered_list_check.
module positional_ordered_list_test;
   import pol_pkg::*;

   localparam int         LIST_DEPTH       = 16;
   // Command code 7 is not used by the block; it must be rejected with the invalid status.
   localparam logic [2:0] CMD_UNUSED       = 3'd7;
   localparam int         RANDOM_PER_PHASE = 22;
   localparam int         WATCHDOG_LIMIT   = 2000;
   localparam int         DRAIN_LIMIT      = 4000;
   // Extra wait after the drain, before the verdict, to catch any stray responses.
   localparam int         SETTLE_CYCLES    = 2 * LIST_DEPTH + 4;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int mismatches;
   int pending;
   int responses_seen;

   // Idling percentages of the current phase, and bookkeeping for stimulus shaping.
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int shadow_len     = 0;
   int requests_sent  = 0;
   int directed_count = 0;
   int idle_cycles    = 0;
   bit filling        = 1'b1;

   positional_ordered_list #(
      .DEPTH(LIST_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   positional_ordered_list_check #(
      .DEPTH(LIST_DEPTH)
   ) u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .mismatches    (mismatches),
      .pending       (pending),
      .responses_seen(responses_seen)
   );

   // Period of 4 ns: two nanoseconds low, two high.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The receiver stalls at random according to the current phase. It never stalls during
   // reset, so the response channel is quiet and defined from the first edge.
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // The watchdog counts cycles in which neither channel completes a handshake. A hang in
   // either direction therefore ends the run rather than leaving it spinning.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type make_request(logic [2:0] cmd, logic signed [31:0] word,
                                            logic [7:0] pos);
      req_type r;
      r.command  = cmd;
      r.value    = word;
      r.position = pos;
      return r;
   endfunction

   // Builds one random request. While filling, inserts dominate so that the list climbs
   // to full and the full cases are exercised; while draining, deletes dominate so that it
   // falls back to empty. Positions are mostly in range, with zero, just past the end and
   // fully random values mixed in.
   function automatic req_type pick_request(int len, bit fill);
      req_type r;
      int      roll;
      int      span;
      roll = $urandom_range(99);
      // The three insert codes are consecutive, as are the three delete codes.
      if (roll < 3) r.command = CMD_UNUSED;
      else if (roll < 12) r.command = CMD_DUMP;
      else if (roll < (fill ? 72 : 34)) r.command = CMD_INS_FRONT + 3'($urandom_range(2));
      else r.command = CMD_DEL_FRONT + 3'($urandom_range(2));

      span = (r.command == CMD_INS_POS) ? len + 1 : len;
      roll = $urandom_range(99);
      if (roll < 65 && span > 0) r.position = 8'($urandom_range(span, 1));
      else if (roll < 75) r.position = '0;
      else if (roll < 88) r.position = 8'(span + $urandom_range(3, 1));
      else r.position = 8'($urandom_range(255));

      roll = $urandom_range(99);
      if (roll < 80) begin
         r.value = $urandom;
      end else begin
         case ($urandom_range(4))
            0: r.value = 32'sh8000_0000;
            1: r.value = 32'sh7FFF_FFFF;
            2: r.value = 32'shFFFF_FFFF;
            3: r.value = 32'sh0000_0001;
            default: r.value = '0;
         endcase
      end
      return r;
   endfunction

   // Offers one request and waits until it is accepted. The random gap lowers valid only
   // when a gap is actually taken, so a back-to-back request keeps valid high without a
   // second assignment in the same time step. The length is tracked here only to steer
   // positions and the fill/drain direction; the checker does the real prediction.
   task automatic send_request(req_type r);
      int pos;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      requests_sent++;

      pos = int'(r.position);
      case (r.command)
         CMD_INS_FRONT, CMD_INS_BACK: begin
            if (shadow_len < LIST_DEPTH) shadow_len++;
         end
         CMD_INS_POS: begin
            if (pos != 0 && shadow_len < LIST_DEPTH && pos <= shadow_len + 1) shadow_len++;
         end
         CMD_DEL_FRONT, CMD_DEL_BACK: begin
            if (shadow_len > 0) shadow_len--;
         end
         CMD_DEL_POS: begin
            if (pos != 0 && shadow_len > 0 && pos <= shadow_len) shadow_len--;
         end
         default: ;
      endcase
   endtask

   initial begin
      int waited;

      // Synchronous reset is held at the start, then released once for the whole run.
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, without any idling. It starts on the empty list: a dump, every
      // delete, zero positions, an insert past the end and the unused command code.
      send_request(make_request(CMD_DUMP,      '0, 8'd0));
      send_request(make_request(CMD_DEL_FRONT, '0, 8'd0));
      send_request(make_request(CMD_DEL_BACK,  '0, 8'd0));
      send_request(make_request(CMD_DEL_POS,   '0, 8'd0));
      send_request(make_request(CMD_DEL_POS,   '0, 8'd1));
      send_request(make_request(CMD_INS_POS,   32'sh1234_5678, 8'd0));
      send_request(make_request(CMD_INS_POS,   32'sh1234_5678, 8'd2));
      send_request(make_request(CMD_UNUSED,    32'shFFFF_FFFF, 8'd255));
      // Inserts of the extreme values at the front, the back, position one, just past the
      // last entry and in the middle.
      send_request(make_request(CMD_INS_FRONT, 32'sh7FFF_FFFF, 8'd0));
      send_request(make_request(CMD_INS_BACK,  32'sh8000_0000, 8'd255));
      send_request(make_request(CMD_INS_POS,   32'shFFFF_FFFF, 8'd1));
      send_request(make_request(CMD_INS_POS,   '0, 8'd4));
      send_request(make_request(CMD_INS_POS,   32'sh5A5A_A5A5, 8'd3));
      // Deletes past the end, then one of each kind with a dump either side.
      send_request(make_request(CMD_DEL_POS,   '0, 8'd6));
      send_request(make_request(CMD_DEL_POS,   '0, 8'd255));
      send_request(make_request(CMD_DUMP,      '0, 8'd0));
      send_request(make_request(CMD_DEL_POS,   '0, 8'd3));
      send_request(make_request(CMD_DEL_FRONT, '0, 8'd0));
      send_request(make_request(CMD_DEL_BACK,  '0, 8'd0));
      send_request(make_request(CMD_DUMP,      '0, 8'd0));
      directed_count = requests_sent;

      // Random part in four idling phases: none, sender gaps, receiver stalls, then both.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 48; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 48; end
            default: begin send_idle_pct = 21; stall_pct = 21; end
         endcase
         repeat (RANDOM_PER_PHASE) begin
            // Turn round at the ends: drain after lingering at full, refill once empty.
            if (shadow_len == 0) filling = 1'b1;
            else if (shadow_len >= LIST_DEPTH && $urandom_range(2) == 0) filling = 1'b0;
            send_request(pick_request(shadow_len, filling));
         end
      end
      req_valid <= 1'b0;

      // Wait for every awaited response, then a little longer to catch any stray ones.
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending != 0 && waited < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (pending != 0) $error("%0d awaited responses never arrived", pending);
      $display("Drove %0d requests (%0d directed, the rest random over four idling phases).",
               requests_sent, directed_count);
      $display("Checked %0d responses field by field; %0d mismatches.",
               responses_seen, mismatches);
      if (mismatches == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
